[hw/rtl/rmf_pkg.sv]
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared constants and types of the running median filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

    localparam int MAX_WINDOW  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_W       = 5;
    localparam int IDX_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(5);

    // one window entry: value and the write slot it came from
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] val;
        logic [IDX_W-1:0]              tag;
    } entry_t;

    // per-cell control from the top level
    typedef struct packed {
        logic rm_before;   // removed entry sits at or left of this cell
        logic c_occ;       // cell is occupied after the removal
    } cell_ctl_t;

endpackage

[hw/rtl/rmf_ifs.sv]
// ----------------------------------------------------------------------------
// rmf_ifs
// Valid/ready channels of the running median filter: samples, results and
// the window size write port.
// ----------------------------------------------------------------------------
interface rmf_sample_if import rmf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface rmf_result_if import rmf_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          window_full;

    modport source (output valid, output filtered, output window_full, input ready);
    modport sink (input valid, input filtered, input window_full, output ready);
endinterface

interface rmf_cfg_if import rmf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink (input valid, input window_size, output ready);
endinterface

[hw/rtl/rmf_cell.sv]
// ----------------------------------------------------------------------------
// rmf_cell
// One slot of the sorted window. Per request the oldest entry is squeezed out
// (cells right of it shift left) and the new sample drops into its sorted place
// (cells right of it shift right), all in one step with the neighbors.
// ----------------------------------------------------------------------------
module rmf_cell
    import rmf_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  cell_ctl_t ctl,
    input  entry_t    ins,
    input  entry_t    left_c,
    input  logic      left_le,
    input  entry_t    right_q,
    output entry_t    q,
    output entry_t    c,
    output logic      c_le,
    output entry_t    q_next
);

    entry_t q_reg;

    always_comb
    begin
        // compacted content after the removal
        c    = ctl.rm_before ? right_q : q_reg;
        c_le = ctl.c_occ && (c.val <= ins.val);
        if (c_le)
            q_next = c;
        else if (left_le)
            q_next = ins;
        else
            q_next = left_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

[hw/rtl/running_median_filter.sv]
// The result is registered at the edge that takes its sample request and is
// offered from the next cycle.
// Throughput: one sample per cycle while results are taken; the whole cell chain
// updates in one step, and a new sample is taken in the same cycle the previous result is taken.
// Reset: write pointer and fill flag cleared, window size back to 5; the cell
// contents are not cleared and are rewritten during the fill before use.
// ----------------------------------------------------------------------------
// running_median_filter
// Sliding-window median over the last N samples held in a sorted cell chain.
// ----------------------------------------------------------------------------
module running_median_filter
    import rmf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    rmf_sample_if.sink    samples,
    rmf_result_if.source  results,
    rmf_cfg_if.sink       cfg
);

    logic [CFG_W-1:0] win_reg;
    logic [IDX_W-1:0] wp_reg;
    logic             filled_reg;
    logic             out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] filtered_reg;
    logic             full_reg;

    logic [CNT_W-1:0] n_eff;
    logic [IDX_W-1:0] mid;
    logic             in_acc;
    logic             wrap;
    logic [MAX_WINDOW-1:0] match;
    entry_t           ins;

    entry_t    q_arr [MAX_WINDOW];
    entry_t    c_arr [MAX_WINDOW];
    entry_t    d_arr [MAX_WINDOW];
    logic      le_arr [MAX_WINDOW];
    cell_ctl_t ctl_arr [MAX_WINDOW];

    always_comb
    begin
        if (win_reg == '0)
            n_eff = CNT_W'(1);
        else if (int'(win_reg) > MAX_WINDOW)
            n_eff = CNT_W'(MAX_WINDOW);
        else
            n_eff = CNT_W'(win_reg);
    end

    assign mid     = IDX_W'(n_eff >> 1);
    assign in_acc  = samples.valid && samples.ready;
    assign wrap    = (CNT_W'(wp_reg) + CNT_W'(1)) == n_eff;
    assign ins.val = samples.sample;
    assign ins.tag = wp_reg;

    assign samples.ready = !out_valid_reg || results.ready;
    assign cfg.ready     = 1'b1;

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        assign match[i] = filled_reg && (i < int'(n_eff)) && (q_arr[i].tag == wp_reg);
        assign ctl_arr[i].rm_before = |match[i:0];
        assign ctl_arr[i].c_occ = filled_reg ? ((i + 1) < int'(n_eff))
                                             : (i < int'(wp_reg));

        rmf_cell u_cell (
            .clk     (clk),
            .en      (in_acc),
            .ctl     (ctl_arr[i]),
            .ins     (ins),
            .left_c  ((i == 0) ? ins : c_arr[(i == 0) ? 0 : i - 1]),
            .left_le ((i == 0) ? 1'b1 : le_arr[(i == 0) ? 0 : i - 1]),
            .right_q (q_arr[(i == MAX_WINDOW - 1) ? i : i + 1]),
            .q       (q_arr[i]),
            .c       (c_arr[i]),
            .c_le    (le_arr[i]),
            .q_next  (d_arr[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= WINDOW_RESET;
            wp_reg        <= '0;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid && cfg.ready)
            begin
                win_reg    <= cfg.window_size;
                wp_reg     <= '0;
                filled_reg <= 1'b0;
            end
            else if (in_acc)
            begin
                if (wrap)
                begin
                    wp_reg     <= '0;
                    filled_reg <= 1'b1;
                end
                else
                    wp_reg <= wp_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (filled_reg || wrap)
            begin
                filtered_reg <= d_arr[mid].val;
                full_reg     <= 1'b1;
            end
            else
            begin
                filtered_reg <= samples.sample;
                full_reg     <= 1'b0;
            end
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.filtered    = filtered_reg;
    assign results.window_full = full_reg;

    // tags form a permutation of the slots once the window is full
    a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg |-> $onehot(match))
        else $error("oldest entry not unique");

    a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(wp_reg) < int'(n_eff))
        else $error("write pointer beyond window");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid_reg)
        else $error("accepted sample left no result");

    a_fill_on_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(filled_reg) |-> $past(in_acc))
        else $error("window filled without a sample");

endmodule
